/* hdl/depth_surface_boundary_marker_defines.svh */
// Assertion macros shared by the depth surface boundary marker modules.
`ifndef DEPTH_SURFACE_BOUNDARY_MARKER_DEFINES_SVH
`define DEPTH_SURFACE_BOUNDARY_MARKER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define DSBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define DSBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dsbm_pkg.sv */
// Types, constants and arithmetic helpers of the depth surface boundary marker.
`timescale 1ns / 1ps

package dsbm_pkg;

    localparam int DEPTH_W    = 16;
    localparam int CLASS_W    = 2;
    localparam int ROW_W      = 9;
    localparam int COL_W      = 10;
    localparam int FOCAL_W    = 22;
    localparam int CENTER_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int PROD_W     = DEPTH_W + FOCAL_W;
    localparam int DR_W       = CENTER_W + 1;
    localparam int DM_W       = DEPTH_W + 10;
    localparam int P_W        = DR_W + DM_W;
    localparam int NUM_W      = P_W + 2;
    localparam int Q_W        = 10;
    localparam int RECIP_W    = 17;
    localparam int RECIP_SHIFT = 23;
    localparam int QP_W       = DEPTH_W + RECIP_W;
    localparam int MAX_RES    = 3;
    localparam int RES_IDX_W  = 2;
    localparam int Q_DEPTH    = 4;

    // Multiplying by 83887 and shifting by 23 gives the exact quotient by 100
    // for every 16-bit depth.
    localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
    localparam logic [6:0]         HUNDRED   = 7'd100;
    localparam logic [9:0]         THOUSAND  = 10'd1000;

    typedef enum logic [CLASS_W-1:0] {
        CLS_VALID = 2'd0,
        CLS_NAN   = 2'd1,
        CLS_INF   = 2'd2
    } t_depth_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DIST  = 3'd0,
        CFG_FOCAL     = 3'd1,
        CFG_CENTER    = 3'd2,
        CFG_CAM_H     = 3'd3,
        CFG_UPPER     = 3'd4,
        CFG_VFLOOR    = 3'd5,
        CFG_HFLOOR    = 3'd6,
        CFG_THRESHOLD = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DEPTH_W-1:0]  max_dist;
        logic [CENTER_W-1:0] center;
        logic [DEPTH_W-1:0]  thr;
        logic [PROD_W-1:0]   cam_f;
        logic [PROD_W-1:0]   upper_f;
        logic [PROD_W-1:0]   vfloor_f;
        logic [PROD_W-1:0]   hfloor_f;
    } t_cfg;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               elig;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } t_qent;

    function automatic logic signed [NUM_W-1:0] f_height_num(
        input logic [PROD_W-1:0]   cam_f,
        input logic signed [P_W-1:0] p
    );
        f_height_num = NUM_W'(cam_f) - NUM_W'(p);
    endfunction

    function automatic logic f_in_band(
        input logic signed [NUM_W-1:0] num,
        input logic [PROD_W-1:0]       floor_f,
        input logic [PROD_W-1:0]       upper_f
    );
        f_in_band = (num > $signed(NUM_W'(floor_f))) && (num < $signed(NUM_W'(upper_f)));
    endfunction

    function automatic logic f_close(
        input logic [DEPTH_W-1:0] a,
        input logic [DEPTH_W-1:0] b,
        input logic [DEPTH_W-1:0] thr
    );
        logic [DEPTH_W-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        f_close = (diff <= thr);
    endfunction

endpackage

/* hdl/dsbm_in_if.sv */
// Input channel carrying one depth pixel per transfer.
`timescale 1ns / 1ps

interface dsbm_in_if import dsbm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DEPTH_W-1:0]  depth_mm;
    logic [CLASS_W-1:0]  depth_class;
    logic [ROW_W-1:0]    pixel_row;
    logic [COL_W-1:0]    pixel_column;

    modport source (output valid, output depth_mm, output depth_class,
                    output pixel_row, output pixel_column, input ready);
    modport sink (input valid, input depth_mm, input depth_class,
                  input pixel_row, input pixel_column, output ready);
endinterface

/* hdl/dsbm_out_if.sv */
// Output channel carrying one pixel mark per transfer.
`timescale 1ns / 1ps

interface dsbm_out_if import dsbm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_column;
    logic               boundary_mark;
    logic               last_of_run;

    modport source (output valid, output out_row, output out_column,
                    output boundary_mark, output last_of_run, input ready);
    modport sink (input valid, input out_row, input out_column,
                  input boundary_mark, input last_of_run, output ready);
endinterface

/* hdl/dsbm_queue.sv */
// Short queue of classified pixels between the front and the back.
`timescale 1ns / 1ps
`include "depth_surface_boundary_marker_defines.svh"

module dsbm_queue import dsbm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_push_data,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_data,
    input  logic  i_pop
);

    localparam int PW = $clog2(Q_DEPTH);

    t_qent          r_mem [Q_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [PW:0]    r_count;

    assign o_full  = (r_count == (PW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `DSBM_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, o_full, !i_push, "push into a full queue")
    `DSBM_ASSERT_IMP(a_q_no_underflow, i_clk, i_rst_n, !o_valid, !i_pop, "pop from an empty queue")

endmodule

/* hdl/dsbm_front.sv */
// Front part: accepts pixels, normalises depth and computes horizontal eligibility.
`timescale 1ns / 1ps

module dsbm_front import dsbm_pkg::*; #(
    parameter int IMAGE_WIDTH  = 672,
    parameter int IMAGE_HEIGHT = 376
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dsbm_in_if.sink  i_pix,
    input  t_cfg     i_cfg,
    input  logic     i_clearing,
    input  logic     i_full,
    output logic     o_push,
    output t_qent    o_push_data
);

    logic                      w_adv;
    logic                      w_acc;
    logic                      w_in_img;
    logic signed [DR_W-1:0]    w_dr;
    logic [QP_W-1:0]           w_q_prod;
    logic [Q_W+6:0]            w_dq;
    logic [DEPTH_W-1:0]        w_depth;
    logic [DM_W-1:0]           w_dm;
    logic signed [DM_W:0]      w_dm_s;
    logic signed [P_W-1:0]     w_p;

    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v;

    logic [DEPTH_W-1:0]        r_s1_raw;
    t_depth_class              r_s1_cls;
    logic [ROW_W-1:0]          r_s1_row;
    logic [COL_W-1:0]          r_s1_col;
    logic signed [DR_W-1:0]    r_s1_dr;

    logic [Q_W-1:0]            r_s2_q;
    t_depth_class              r_s2_cls;
    logic [ROW_W-1:0]          r_s2_row;
    logic [COL_W-1:0]          r_s2_col;
    logic signed [DR_W-1:0]    r_s2_dr;

    logic [DEPTH_W-1:0]        r_s3_d;
    logic [ROW_W-1:0]          r_s3_row;
    logic [COL_W-1:0]          r_s3_col;
    logic signed [DR_W-1:0]    r_s3_dr;

    logic [DM_W-1:0]           r_s4_dm;
    logic [DEPTH_W-1:0]        r_s4_d;
    logic [ROW_W-1:0]          r_s4_row;
    logic [COL_W-1:0]          r_s4_col;
    logic signed [DR_W-1:0]    r_s4_dr;

    logic signed [P_W-1:0]     r_s5_p;
    logic [DEPTH_W-1:0]        r_s5_d;
    logic [ROW_W-1:0]          r_s5_row;
    logic [COL_W-1:0]          r_s5_col;

    logic signed [NUM_W-1:0]   r_s6_num;
    logic [DEPTH_W-1:0]        r_s6_d;
    logic [ROW_W-1:0]          r_s6_row;
    logic [COL_W-1:0]          r_s6_col;

    t_qent                     r_s7;

    assign w_adv       = !(r_s7_v && i_full);
    assign i_pix.ready = w_adv && !i_clearing;
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_in_img    = (32'(i_pix.pixel_row) < IMAGE_HEIGHT) &&
                         (32'(i_pix.pixel_column) < IMAGE_WIDTH);
    assign w_dr        = DR_W'(i_pix.pixel_row) - DR_W'(i_cfg.center);

    assign w_q_prod    = r_s1_raw * RECIP_100;
    assign w_dq        = r_s2_q * HUNDRED;
    assign w_dm        = r_s3_d * THOUSAND;
    assign w_dm_s      = {1'b0, r_s4_dm};
    assign w_p         = r_s4_dr * w_dm_s;

    always_comb begin
        unique case (r_s2_cls)
            CLS_VALID: w_depth = w_dq[DEPTH_W-1:0];
            CLS_INF:   w_depth = i_cfg.max_dist;
            default:   w_depth = '0;
        endcase
    end

    assign o_push      = r_s7_v && !i_full;
    assign o_push_data = r_s7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= w_acc && w_in_img;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_raw   <= i_pix.depth_mm;
            r_s1_cls   <= t_depth_class'(i_pix.depth_class);
            r_s1_row   <= i_pix.pixel_row;
            r_s1_col   <= i_pix.pixel_column;
            r_s1_dr    <= w_dr;

            r_s2_q     <= w_q_prod[RECIP_SHIFT +: Q_W];
            r_s2_cls   <= r_s1_cls;
            r_s2_row   <= r_s1_row;
            r_s2_col   <= r_s1_col;
            r_s2_dr    <= r_s1_dr;

            r_s3_d     <= w_depth;
            r_s3_row   <= r_s2_row;
            r_s3_col   <= r_s2_col;
            r_s3_dr    <= r_s2_dr;

            r_s4_dm    <= w_dm;
            r_s4_d     <= r_s3_d;
            r_s4_row   <= r_s3_row;
            r_s4_col   <= r_s3_col;
            r_s4_dr    <= r_s3_dr;

            r_s5_p     <= w_p;
            r_s5_d     <= r_s4_d;
            r_s5_row   <= r_s4_row;
            r_s5_col   <= r_s4_col;

            r_s6_num   <= f_height_num(i_cfg.cam_f, r_s5_p);
            r_s6_d     <= r_s5_d;
            r_s6_row   <= r_s5_row;
            r_s6_col   <= r_s5_col;

            r_s7.depth <= r_s6_d;
            r_s7.elig  <= (r_s6_d != '0) &&
                          f_in_band(r_s6_num, i_cfg.hfloor_f, i_cfg.upper_f);
            r_s7.row   <= r_s6_row;
            r_s7.col   <= r_s6_col;
        end
    end

endmodule

/* hdl/dsbm_back.sv */
// Back part: line buffers, neighbour tests and result sequencing.
`timescale 1ns / 1ps
`include "depth_surface_boundary_marker_defines.svh"

module dsbm_back import dsbm_pkg::*; #(
    parameter int IMAGE_WIDTH  = 672,
    parameter int IMAGE_HEIGHT = 376
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_qent      i_q_data,
    output logic       o_pop,
    output logic       o_clearing,
    dsbm_out_if.source o_res
);

    localparam int AW = $clog2(IMAGE_WIDTH);

    logic [DEPTH_W-1:0]        r_depth_mem [IMAGE_WIDTH];
    logic                      r_side_mem  [IMAGE_WIDTH];

    logic                      r_clr_busy;
    logic [AW-1:0]             r_clr_cnt;

    logic                      r_b1_v, r_b2_v, r_b3_v, r_b4_v;
    t_qent                     r_b1, r_b2, r_b3, r_b4;
    logic [DEPTH_W-1:0]        r_b1_up;
    logic [DM_W-1:0]           r_b2_dm;
    logic signed [DR_W-1:0]    r_b2_dr;
    logic                      r_b2_close, r_b3_close, r_b4_close;
    logic                      r_b2_nz, r_b3_nz, r_b4_nz;
    logic signed [P_W-1:0]     r_b3_p;
    logic signed [NUM_W-1:0]   r_b4_num;
    logic                      r_b4_sm_mem;
    logic                      r_b4_fwd_hit;
    logic                      r_b4_fwd_val;

    logic [DEPTH_W-1:0]        r_left_d;
    logic                      r_left_elig;

    logic                      r_em_valid;
    logic [RES_IDX_W-1:0]      r_em_idx;
    logic [RES_IDX_W-1:0]      r_em_n;
    logic [ROW_W-1:0]          r_em_row  [MAX_RES];
    logic [COL_W-1:0]          r_em_col  [MAX_RES];
    logic                      r_em_mark [MAX_RES];

    logic                      w_adv;
    logic                      w_pop;
    logic [AW-1:0]             w_pop_addr;
    logic signed [DR_W-1:0]    w_b1_dr;
    logic signed [DM_W:0]      w_b2_dm_s;
    logic                      w_b4_sm;
    logic                      w_b4_mark;
    logic                      w_b4_side;
    logic                      w_b4_bottom;
    logic                      w_b4_has_b;
    logic                      w_b4_has_c;
    logic [RES_IDX_W-1:0]      w_b4_n;
    logic                      w_side_we;
    logic [AW-1:0]             w_side_waddr;
    logic [AW-1:0]             w_side_raddr;
    logic                      w_em_last;
    logic                      w_em_take;
    logic                      w_em_load;

    assign o_clearing   = r_clr_busy;

    assign w_em_last    = ((r_em_idx + RES_IDX_W'(1)) == r_em_n);
    assign w_em_take    = !r_em_valid || (o_res.ready && w_em_last);
    assign w_adv        = !r_b4_v || (w_b4_n == '0) || w_em_take;
    assign w_pop        = w_adv && i_q_valid && !r_clr_busy;
    assign o_pop        = w_pop;
    assign w_pop_addr   = AW'(i_q_data.col);

    assign w_b1_dr      = DR_W'(r_b1.row) - DR_W'(i_cfg.center) - DR_W'(1);
    assign w_b2_dm_s    = {1'b0, r_b2_dm};

    assign w_b4_sm      = r_b4_fwd_hit ? r_b4_fwd_val : r_b4_sm_mem;
    assign w_b4_mark    = (r_b4_nz && r_b4_close &&
                           f_in_band(r_b4_num, i_cfg.vfloor_f, i_cfg.upper_f)) || w_b4_sm;
    assign w_b4_side    = r_left_elig && f_close(r_left_d, r_b4.depth, i_cfg.thr);
    assign w_b4_bottom  = (32'(r_b4.row) == IMAGE_HEIGHT - 1);
    assign w_b4_has_b   = w_b4_bottom && (r_b4.col != '0);
    assign w_b4_has_c   = w_b4_bottom && (32'(r_b4.col) == IMAGE_WIDTH - 1);
    assign w_b4_n       = (r_b4.row == '0) ? '0 :
                          RES_IDX_W'(1) + RES_IDX_W'(w_b4_has_b) + RES_IDX_W'(w_b4_has_c);

    assign w_side_we    = w_adv && r_b4_v && (r_b4.col != '0);
    assign w_side_waddr = AW'(r_b4.col) - AW'(1);
    assign w_side_raddr = AW'(r_b3.col);
    assign w_em_load    = w_adv && r_b4_v && (w_b4_n != '0);

    assign o_res.valid         = r_em_valid;
    assign o_res.out_row       = r_em_row[r_em_idx];
    assign o_res.out_column    = r_em_col[r_em_idx];
    assign o_res.boundary_mark = r_em_mark[r_em_idx];
    assign o_res.last_of_run   = w_em_last;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_depth_mem[r_clr_cnt] <= '0;
        end else if (w_pop) begin
            r_depth_mem[w_pop_addr] <= i_q_data.depth;
        end
        if (w_pop) begin
            r_b1_up <= r_depth_mem[w_pop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_side_mem[r_clr_cnt] <= 1'b0;
        end else if (w_side_we) begin
            r_side_mem[w_side_waddr] <= w_b4_side;
        end
        if (w_adv) begin
            r_b4_sm_mem <= r_side_mem[w_side_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_b1_v      <= 1'b0;
            r_b2_v      <= 1'b0;
            r_b3_v      <= 1'b0;
            r_b4_v      <= 1'b0;
            r_left_d    <= '0;
            r_left_elig <= 1'b0;
            r_em_valid  <= 1'b0;
            r_em_idx    <= '0;
            r_em_n      <= '0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_cnt == AW'(IMAGE_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_cnt <= r_clr_cnt + AW'(1);
                end
            end
            if (w_adv) begin
                r_b1_v <= w_pop;
                r_b2_v <= r_b1_v;
                r_b3_v <= r_b2_v;
                r_b4_v <= r_b3_v;
            end
            if (w_adv && r_b4_v) begin
                r_left_d    <= r_b4.depth;
                r_left_elig <= r_b4.elig;
            end
            if (w_em_load) begin
                r_em_valid <= 1'b1;
                r_em_idx   <= '0;
                r_em_n     <= w_b4_n;
            end else if (r_em_valid && o_res.ready) begin
                if (w_em_last) begin
                    r_em_valid <= 1'b0;
                end else begin
                    r_em_idx <= r_em_idx + RES_IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_b1 <= i_q_data;
        end
        if (w_adv) begin
            r_b2         <= r_b1;
            r_b2_dm      <= r_b1_up * THOUSAND;
            r_b2_dr      <= w_b1_dr;
            r_b2_close   <= f_close(r_b1_up, r_b1.depth, i_cfg.thr);
            r_b2_nz      <= (r_b1_up != '0);

            r_b3         <= r_b2;
            r_b3_p       <= r_b2_dr * w_b2_dm_s;
            r_b3_close   <= r_b2_close;
            r_b3_nz      <= r_b2_nz;

            r_b4         <= r_b3;
            r_b4_num     <= f_height_num(i_cfg.cam_f, r_b3_p);
            r_b4_close   <= r_b3_close;
            r_b4_nz      <= r_b3_nz;
            r_b4_fwd_hit <= w_side_we && (w_side_waddr == w_side_raddr);
            r_b4_fwd_val <= w_b4_side;
        end
        if (w_em_load) begin
            r_em_row[0]  <= r_b4.row - ROW_W'(1);
            r_em_col[0]  <= r_b4.col;
            r_em_mark[0] <= w_b4_mark;
            r_em_row[1]  <= r_b4.row;
            r_em_col[1]  <= r_b4.col - COL_W'(1);
            r_em_mark[1] <= w_b4_side;
            r_em_row[2]  <= r_b4.row;
            r_em_col[2]  <= r_b4.col;
            r_em_mark[2] <= 1'b0;
        end
    end

    `DSBM_ASSERT_IMP(a_no_pop_in_clear, i_clk, i_rst_n, r_clr_busy, !w_pop, "pop during line buffer clear")
    `DSBM_ASSERT_IMP(a_em_idx_range, i_clk, i_rst_n, r_em_valid, (r_em_idx < r_em_n), "result index beyond count")
    `DSBM_ASSERT_NXT(a_em_drain, i_clk, i_rst_n, r_em_valid && o_res.ready && w_em_last && !w_em_load, !r_em_valid, "result repeated after last transfer")
    `DSBM_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, w_em_load && r_em_valid, o_res.ready && w_em_last, "result overwritten before transfer")

endmodule

/* hdl/depth_surface_boundary_marker.sv */
// Top level of the depth surface boundary marker: configuration registers and part wiring.
`timescale 1ns / 1ps
//
// Channel  Dir  Transfer at             Payload
// i_pix    in   valid && ready          depth_mm, depth_class, pixel_row, pixel_column
// o_res    out  valid && ready          out_row, out_column, boundary_mark, last_of_run
// cfg      in   i_cfg_we                i_cfg_idx, i_cfg_data
//
// One pixel is taken per cycle unless a full queue or the line buffer clear stalls it.
// A pixel of row zero yields no result and others one, but on the bottom row a pixel yields
// two (one at column zero, three at the last column), and the single result port then sets
// the pace at one result per cycle while o_res is ready.
// A pixel passes seven front stages, the queue, four back stages and the result register
// before its first result. After reset the line buffers are cleared entry by entry,
// during which i_pix is not ready; configuration writes are taken throughout.
// A stalled result port fills the four-entry queue before the input is held back.

module depth_surface_boundary_marker import dsbm_pkg::*; #(
    parameter int IMAGE_WIDTH  = 672,
    parameter int IMAGE_HEIGHT = 376
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dsbm_in_if.sink               i_pix,
    dsbm_out_if.source            o_res
);

    logic [DEPTH_W-1:0]  r_max_dist;
    logic [FOCAL_W-1:0]  r_focal;
    logic [CENTER_W-1:0] r_center;
    logic [DEPTH_W-1:0]  r_cam_h;
    logic [DEPTH_W-1:0]  r_upper;
    logic [DEPTH_W-1:0]  r_vfloor;
    logic [DEPTH_W-1:0]  r_hfloor;
    logic [DEPTH_W-1:0]  r_thr;

    logic [PROD_W-1:0]   r_cam_f;
    logic [PROD_W-1:0]   r_upper_f;
    logic [PROD_W-1:0]   r_vfloor_f;
    logic [PROD_W-1:0]   r_hfloor_f;

    t_cfg                w_cfg;
    logic                w_clearing;
    logic                w_full;
    logic                w_push;
    t_qent               w_push_data;
    logic                w_q_valid;
    t_qent               w_q_data;
    logic                w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist <= 16'd5000;
            r_focal    <= 22'd350505;
            r_center   <= 12'd191;
            r_cam_h    <= 16'd215;
            r_upper    <= 16'd700;
            r_vfloor   <= 16'd50;
            r_hfloor   <= 16'd0;
            r_thr      <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_DIST:  r_max_dist <= i_cfg_data[DEPTH_W-1:0];
                CFG_FOCAL:     r_focal    <= i_cfg_data[FOCAL_W-1:0];
                CFG_CENTER:    r_center   <= i_cfg_data[CENTER_W-1:0];
                CFG_CAM_H:     r_cam_h    <= i_cfg_data[DEPTH_W-1:0];
                CFG_UPPER:     r_upper    <= i_cfg_data[DEPTH_W-1:0];
                CFG_VFLOOR:    r_vfloor   <= i_cfg_data[DEPTH_W-1:0];
                CFG_HFLOOR:    r_hfloor   <= i_cfg_data[DEPTH_W-1:0];
                CFG_THRESHOLD: r_thr      <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Height limits scaled by the focal length, so the band test needs no division.
    always_ff @(posedge i_clk) begin
        r_cam_f    <= r_cam_h * r_focal;
        r_upper_f  <= r_upper * r_focal;
        r_vfloor_f <= r_vfloor * r_focal;
        r_hfloor_f <= r_hfloor * r_focal;
    end

    assign w_cfg = '{
        max_dist: r_max_dist,
        center:   r_center,
        thr:      r_thr,
        cam_f:    r_cam_f,
        upper_f:  r_upper_f,
        vfloor_f: r_vfloor_f,
        hfloor_f: r_hfloor_f
    };

    dsbm_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (w_cfg),
        .i_clearing  (w_clearing),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    dsbm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .o_valid     (w_q_valid),
        .o_data      (w_q_data),
        .i_pop       (w_pop)
    );

    dsbm_back #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_q_data),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_res      (o_res)
    );

endmodule
